FILE: hdl/fsd_pkg.sv
// ----------------------------------------------------------------------------
// fsd_pkg
// Codes, constants and the hash step shared by the frame settle detector.
// ----------------------------------------------------------------------------
package fsd_pkg;

	// Input operation codes
	typedef logic [1:0] op_t;
	localparam op_t OP_BYTE      = 2'd0;
	localparam op_t OP_FRAME_END = 2'd1;
	localparam op_t OP_FORGET    = 2'd2;
	localparam op_t OP_SETTINGS  = 2'd3;

	// Result action codes
	typedef logic [1:0] action_t;
	localparam action_t ACT_CLEAR   = 2'd0;
	localparam action_t ACT_CHANGED = 2'd1;
	localparam action_t ACT_NONE    = 2'd2;
	localparam action_t ACT_SCAN    = 2'd3;

	// Configuration register indexes
	typedef logic cfg_idx_t;
	localparam cfg_idx_t REG_FRAME_SIZE  = 1'b0;
	localparam cfg_idx_t REG_SETTLE_TIME = 1'b1;

	// Sampling: stride is frame_size >> floor(log2(SAMPLE_COUNT)), forced odd
	localparam int SAMPLE_COUNT = 512;
	localparam int SAMPLE_SHIFT = $clog2(SAMPLE_COUNT + 1) - 1;

	localparam logic [23:0] POS_MAX       = 24'hFFFFFF;
	localparam logic [23:0] FRAME_SIZE_RST = 24'd1572864;
	localparam logic [31:0] SETTLE_RST    = 32'd300000;

	// FNV-1a 32-bit
	localparam logic [31:0] HASH_BASIS = 32'h811C9DC5;

	// One FNV-1a step; prime 0x01000193 = 2^24 + 2^8 + 2^7 + 2^4 + 2^1 + 1
	function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
		logic [31:0] x;
		x = h ^ {24'd0, b};
		return (x << 24) + (x << 8) + (x << 7) + (x << 4) + (x << 1) + x;
	endfunction

endpackage

FILE: hdl/frame_settle_detector_top.sv
// ----------------------------------------------------------------------------
// frame_settle_detector_top
// Hashes sampled frame bytes and decides when a still picture is ready to scan.
//
// Usage:
//   Input channel (in_valid / in_stall) carries op, pixel_byte, now_time and
//   read_worthy. Frame bytes and settings-changed events give no result;
//   frame end and forget each give one result on the output channel
//   (out_valid / out_stall) with action and signature.
//   Path: an item that gives a result waits in the input register, and its
//   result is then held in the result register, which drives the outputs.
//   Throughput: one item per cycle while in_stall is low; the hash step,
//   the sample position update and the 63-bit time compare each fit between
//   the input and result registers, so nothing iterates.
//   When the receiver stalls, the result register holds its item; frame bytes
//   and settings events keep flowing, and the input stalls only while an item
//   that makes a result waits in the input register for the full result
//   register.
//   Reset clears the hash to the FNV basis, the byte counters, the held
//   signature, change time and scan flag, and loads frame_size = 1572864 and
//   settle_time = 300000. Configuration is written through cfg_we.
// ----------------------------------------------------------------------------
module frame_settle_detector_top
	import fsd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	// configuration write port
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,

	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [7:0]  pixel_byte,
	input  logic [62:0] now_time,
	input  logic        read_worthy,

	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  action,
	output logic [31:0] signature
);

	// configuration registers
	logic [23:0] frame_size_q;
	logic [31:0] settle_time_q;

	// block state
	logic [31:0] hash_q;
	logic [31:0] held_sig_q;
	logic [62:0] change_time_q;
	logic        scan_done_q;
	logic [23:0] byte_pos_q;
	logic [23:0] next_pos_q;

	// input register
	logic        valid_s1;
	op_t         op_s1;
	logic [7:0]  pixel_s1;
	logic [62:0] now_s1;
	logic        worthy_s1;

	// result register
	logic        out_valid_q;
	action_t     action_q;
	logic [31:0] sig_q;

	// next-state values
	logic [31:0] hash_d;
	logic [31:0] held_sig_d;
	logic [62:0] change_time_d;
	logic        scan_done_d;
	logic [23:0] byte_pos_d;
	logic [23:0] next_pos_d;
	action_t     act_d;
	logic [31:0] sig_d;

	logic        has_result;
	logic        out_free;
	logic        go;
	logic        sample_hit;
	logic [23:0] stride;
	logic [24:0] next_sum;
	logic [63:0] time_diff;
	logic        settled;

	// handshake: the input register advances unless its result has nowhere to go
	assign has_result = (op_s1 == OP_FRAME_END) || (op_s1 == OP_FORGET);
	assign out_free   = !out_valid_q || !out_stall;
	assign go         = valid_s1 && (!has_result || out_free);
	assign in_stall   = valid_s1 && !go;

	// sampling and settle timing
	assign sample_hit = (byte_pos_q == next_pos_q) && (byte_pos_q < frame_size_q);
	assign stride     = (frame_size_q >> SAMPLE_SHIFT) | 24'd1;
	assign next_sum   = {1'b0, next_pos_q} + {1'b0, stride};
	assign time_diff  = {1'b0, now_s1} - {1'b0, change_time_q};
	assign settled    = !time_diff[63] && (time_diff[62:0] >= {31'd0, settle_time_q});

	// per-item work
	always_comb begin
		hash_d        = hash_q;
		held_sig_d    = held_sig_q;
		change_time_d = change_time_q;
		scan_done_d   = scan_done_q;
		byte_pos_d    = byte_pos_q;
		next_pos_d    = next_pos_q;
		act_d         = ACT_NONE;
		sig_d         = hash_q;
		unique case (op_s1)
			OP_BYTE: begin
				if (sample_hit) begin
					hash_d     = fnv_step(hash_q, pixel_s1);
					next_pos_d = next_sum[24] ? POS_MAX : next_sum[23:0];
				end
				if (byte_pos_q != POS_MAX) begin
					byte_pos_d = byte_pos_q + 24'd1;
				end
			end
			OP_FRAME_END: begin
				hash_d     = HASH_BASIS;
				byte_pos_d = 24'd0;
				next_pos_d = 24'd0;
				priority if (!worthy_s1) begin
					if (held_sig_q != 32'd0) begin
						held_sig_d  = 32'd0;
						scan_done_d = 1'b0;
						act_d       = ACT_CLEAR;
					end
				end else if (hash_q != held_sig_q) begin
					held_sig_d    = hash_q;
					change_time_d = now_s1;
					scan_done_d   = 1'b0;
					act_d         = ACT_CHANGED;
				end else if (scan_done_q || !settled) begin
					act_d = ACT_NONE;
				end else begin
					scan_done_d = 1'b1;
					act_d       = ACT_SCAN;
				end
			end
			OP_FORGET: begin
				scan_done_d = 1'b0;
				act_d       = ACT_CLEAR;
				sig_d       = 32'd0;
			end
			OP_SETTINGS: begin
				scan_done_d = 1'b0;
			end
		endcase
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_size_q  <= FRAME_SIZE_RST;
			settle_time_q <= SETTLE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_SIZE:  frame_size_q  <= cfg_data[23:0];
				REG_SETTLE_TIME: settle_time_q <= cfg_data;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1     <= op;
			pixel_s1  <= pixel_byte;
			now_s1    <= now_time;
			worthy_s1 <= read_worthy;
		end
	end

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q        <= HASH_BASIS;
			held_sig_q    <= 32'd0;
			change_time_q <= 63'd0;
			scan_done_q   <= 1'b0;
			byte_pos_q    <= 24'd0;
			next_pos_q    <= 24'd0;
		end else if (go) begin
			hash_q        <= hash_d;
			held_sig_q    <= held_sig_d;
			change_time_q <= change_time_d;
			scan_done_q   <= scan_done_d;
			byte_pos_q    <= byte_pos_d;
			next_pos_q    <= next_pos_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go && has_result) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && has_result) begin
			action_q <= act_d;
			sig_q    <= sig_d;
		end
	end

	assign out_valid = out_valid_q;
	assign action    = action_q;
	assign signature = sig_q;

endmodule
